>>> rtl/cwi_pkg.sv
package cwi_pkg;

	localparam int unsigned MaxSubflowsDefault = 8;
	localparam logic [15:0] SegmentSizeReset = 16'd1460;
	localparam logic [23:0] RttMax = 24'hFFFFFF;

	typedef enum logic [1:0] {
		OP_REPORT = 2'd0,
		OP_ACK    = 2'd1,
		OP_DEACT  = 2'd2,
		OP_UNUSED = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [2:0]  subflow;
		logic [31:0] window_value;
		logic [23:0] rtt_us;
		logic [31:0] slow_start_threshold;
	} cwi_req_t;

	typedef struct packed {
		logic [2:0]  out_subflow;
		logic [31:0] new_window;
		logic [31:0] increment;
		logic        in_slow_start;
		logic        status;
	} cwi_rsp_t;

endpackage

>>> rtl/coupled_window_increase_top.sv
// Channel  | Direction | Handshake             | Payload
// req      | in        | req_valid / req_ready | cwi_pkg::cwi_req_t
// rsp      | out       | rsp_valid / rsp_ready | cwi_pkg::cwi_rsp_t
// cfg      | in        | cfg_we                | segment_size (16 bits)
//
// Reports, deactivates, unused opcodes and ACKs on inactive subflows go from
// decode straight to done; slow-start ACKs pass the apply step first. A coupled
// ACK walks the subflows through one shared 128/64 bit restoring divider (one
// quotient bit per cycle): it scans every table entry, divides for q and s on each
// active subflow, then for t and u, multiplies, and divides for the cap before the
// apply step (t, u and the multiply are skipped when the sum is zero). Reset at
// once clears the windows and active flags and sets every RTT to RttMax.
// The block takes no request until the response has been taken.
module coupled_window_increase_top #(
	parameter int unsigned MAX_SUBFLOWS = cwi_pkg::MaxSubflowsDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [15:0]       cfg_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  cwi_pkg::cwi_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output cwi_pkg::cwi_rsp_t rsp
);
	import cwi_pkg::*;

	localparam int unsigned SfW = (MAX_SUBFLOWS > 1) ? $clog2(MAX_SUBFLOWS) : 1;

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_DECODE = 11'b00000000010,
		ST_SCAN   = 11'b00000000100,
		ST_DIVQ   = 11'b00000001000,
		ST_DIVS   = 11'b00000010000,
		ST_DIVT   = 11'b00000100000,
		ST_DIVU   = 11'b00001000000,
		ST_MULHI  = 11'b00010000000,
		ST_MULLO  = 11'b00100000000,
		ST_DIVCAP = 11'b01000000000,
		ST_DONE   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [15:0] mss_q;
	logic [MAX_SUBFLOWS-1:0] active_q;
	logic [31:0] win_q [MAX_SUBFLOWS];
	logic [23:0] rtt_q [MAX_SUBFLOWS];

	cwi_req_t req_q;
	logic [SfW-1:0] idx_q;
	logic [31:0] cw_q;
	logic [63:0] m_q, s_q, t_q, v_q;
	logic [31:0] mss2_q;
	logic sat_q;

	// Shared restoring divider: {hi,lo} / d, one bit per cycle.
	logic [63:0] rem_q, lo_q, quo_q, div_d_q;
	logic [6:0]  cnt_q;
	logic        div_busy_q;
	logic [64:0] rem_sh;
	logic        take;
	logic [63:0] rem_nx;

	assign rem_sh = {rem_q, lo_q[63]};
	assign take   = (rem_sh >= {1'b0, div_d_q});
	assign rem_nx = take ? 64'(rem_sh - {1'b0, div_d_q}) : rem_sh[63:0];

	logic in_range;
	logic [SfW-1:0] sf_idx;
	assign in_range = ({29'd0, req_q.subflow} < 32'(MAX_SUBFLOWS));
	assign sf_idx   = SfW'(req_q.subflow);

	logic [31:0] rr_lo; // r*r fits 48 bits
	logic [47:0] rsq;
	assign rsq   = 48'(rtt_q[idx_q]) * 48'(rtt_q[idx_q]);
	assign rr_lo = rsq[31:0];

	logic [63:0] mul_p;
	logic [31:0] mul_b;
	assign mul_b = (state_q == ST_MULHI) ? t_q[63:32] : t_q[31:0];
	assign mul_p = 64'(mss2_q) * 64'(mul_b);

	logic [64:0] s_add;
	logic [32:0] w_add;
	assign s_add = {1'b0, s_q} + {1'b0, quo_q};

	logic [31:0] add_q;
	assign w_add = {1'b0, cw_q} + {1'b0, add_q};

	logic last_idx;
	assign last_idx = (32'(idx_q) == 32'(MAX_SUBFLOWS - 1));

	assign req_ready = (state_q == ST_IDLE) && !rsp_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mss_q      <= SegmentSizeReset;
			active_q   <= '0;
			rsp_valid  <= 1'b0;
			div_busy_q <= 1'b0;
			for (int i = 0; i < MAX_SUBFLOWS; i++) begin
				win_q[i] <= '0;
				rtt_q[i] <= RttMax;
			end
		end else begin
			if (cfg_we) begin
				mss_q <= cfg_data;
			end
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			if (div_busy_q) begin
				rem_q <= rem_nx;
				lo_q  <= {lo_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], take};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					div_busy_q <= 1'b0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid && req_ready) begin
						req_q   <= req;
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					rsp.out_subflow <= req_q.subflow;
					rsp.increment   <= '0;
					if (!in_range) begin
						rsp.new_window    <= '0;
						rsp.in_slow_start <= 1'b0;
						rsp.status        <= (req_q.opcode == OP_ACK);
						state_q           <= ST_DONE;
					end else begin
						case (opcode_t'(req_q.opcode))
							OP_REPORT: begin
								win_q[sf_idx]     <= req_q.window_value;
								rtt_q[sf_idx]     <= (req_q.rtt_us == '0) ? 24'd1 : req_q.rtt_us;
								active_q[sf_idx]  <= 1'b1;
								rsp.new_window    <= req_q.window_value;
								rsp.in_slow_start <= 1'b0;
								rsp.status        <= 1'b0;
								state_q           <= ST_DONE;
							end
							OP_ACK: begin
								rsp.new_window <= win_q[sf_idx];
								cw_q           <= win_q[sf_idx];
								if (!active_q[sf_idx]) begin
									rsp.in_slow_start <= 1'b0;
									rsp.status        <= 1'b1;
									state_q           <= ST_DONE;
								end else if (win_q[sf_idx] < req_q.slow_start_threshold) begin
									add_q             <= {16'd0, mss_q};
									rsp.in_slow_start <= 1'b1;
									rsp.status        <= 1'b0;
									state_q           <= ST_MULLO; // reused as the apply step
									sat_q             <= 1'b1;
								end else begin
									rsp.in_slow_start <= 1'b0;
									rsp.status        <= 1'b0;
									mss2_q  <= 32'(mss_q) * 32'(mss_q);
									m_q     <= '0;
									s_q     <= '0;
									idx_q   <= '0;
									sat_q   <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
							OP_DEACT: begin
								active_q[sf_idx]  <= 1'b0;
								rsp.new_window    <= win_q[sf_idx];
								rsp.in_slow_start <= 1'b0;
								rsp.status        <= 1'b0;
								state_q           <= ST_DONE;
							end
							default: begin
								rsp.new_window    <= win_q[sf_idx];
								rsp.in_slow_start <= 1'b0;
								rsp.status        <= 1'b0;
								state_q           <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (active_q[idx_q]) begin
						// q = (c<<32) / r^2, where r^2 < 2^48.
						rem_q      <= '0;
						lo_q       <= {win_q[idx_q], 32'd0};
						div_d_q    <= {16'd0, rsq[47:32], rr_lo};
						cnt_q      <= 7'd64;
						div_busy_q <= 1'b1;
						state_q    <= ST_DIVQ;
					end else if (last_idx) begin
						state_q <= ST_DIVT;
						if (s_q != '0) begin
							rem_q      <= {32'd0, m_q[63:32]};
							lo_q       <= {m_q[31:0], 32'd0};
							div_d_q    <= s_q;
							cnt_q      <= 7'd64;
							div_busy_q <= 1'b1;
						end
					end else begin
						idx_q <= idx_q + SfW'(1);
					end
				end
				ST_DIVQ: begin
					if (!div_busy_q) begin
						if (quo_q > m_q) begin
							m_q <= quo_q;
						end
						rem_q      <= '0;
						lo_q       <= {win_q[idx_q], 32'd0};
						div_d_q    <= {40'd0, rtt_q[idx_q]};
						cnt_q      <= 7'd64;
						div_busy_q <= 1'b1;
						state_q    <= ST_DIVS;
					end
				end
				ST_DIVS: begin
					if (!div_busy_q) begin
						s_q <= s_add[64] ? '1 : s_add[63:0];
						if (last_idx) begin
							state_q <= ST_DIVT;
							if ((s_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s_add[63:0]) != '0) begin
								rem_q      <= {32'd0, m_q[63:32]};
								lo_q       <= {m_q[31:0], 32'd0};
								div_d_q    <= s_add[64] ? '1 : s_add[63:0];
								cnt_q      <= 7'd64;
								div_busy_q <= 1'b1;
							end
						end else begin
							idx_q   <= idx_q + SfW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_DIVT: begin
					if (!div_busy_q) begin
						if (s_q == '0) begin
							v_q     <= '0;
							state_q <= ST_DIVCAP;
							rem_q      <= '0;
							lo_q       <= {mss2_q, 32'd0};
							div_d_q    <= {32'd0, (cw_q == '0) ? 32'd1 : cw_q};
							cnt_q      <= 7'd32;
							div_busy_q <= 1'b1;
						end else begin
							// hi of m is below 2^32 here; saturation when it reaches S.
							t_q <= ({32'd0, m_q[63:32]} >= s_q) ? '1 : quo_q;
							rem_q      <= ({32'd0, m_q[63:32]} >= s_q) ? 64'hFFFF_FFFF : {32'd0, quo_q[63:32]};
							lo_q       <= ({32'd0, m_q[63:32]} >= s_q) ? 64'hFFFF_FFFF_0000_0000
							              : {quo_q[31:0], 32'd0};
							cnt_q      <= 7'd64;
							div_busy_q <= 1'b1;
							state_q    <= ST_DIVU;
						end
					end
				end
				ST_DIVU: begin
					if (!div_busy_q) begin
						t_q     <= ({32'd0, t_q[63:32]} >= s_q) ? '1 : quo_q;
						state_q <= ST_MULHI;
					end
				end
				ST_MULHI: begin
					v_q     <= mul_p;
					state_q <= ST_MULLO;
				end
				ST_MULLO: begin
					if (sat_q) begin
						// Apply step: window grows by add_q and saturates.
						win_q[sf_idx]  <= w_add[32] ? '1 : w_add[31:0];
						rsp.new_window <= w_add[32] ? '1 : w_add[31:0];
						rsp.increment  <= 32'((w_add[32] ? 33'h0FFFF_FFFF : w_add) - {1'b0, cw_q});
						state_q        <= ST_DONE;
					end else begin
						v_q        <= v_q + {32'd0, mul_p[63:32]};
						rem_q      <= '0;
						lo_q       <= {mss2_q, 32'd0};
						div_d_q    <= {32'd0, (cw_q == '0) ? 32'd1 : cw_q};
						cnt_q      <= 7'd32;
						div_busy_q <= 1'b1;
						state_q    <= ST_DIVCAP;
					end
				end
				ST_DIVCAP: begin
					if (!div_busy_q) begin
						// The cap quotient is in the low 32 bits after 32 steps.
						add_q   <= (v_q < {32'd0, quo_q[31:0]}) ? v_q[31:0] : quo_q[31:0];
						sat_q   <= 1'b1;
						state_q <= ST_MULLO;
					end
				end
				ST_DONE: begin
					rsp_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ap_no_req_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_ready)
		else $error("request taken while busy");
	ap_rsp_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> rsp_valid)
		else $error("response missing after done");
	ap_divider_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> (cnt_q != 7'd0))
		else $error("divider count underflow");
	ap_ss_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.in_slow_start) |-> !rsp.status)
		else $error("slow start flagged on ignored request");

endmodule
